/* hdl/replacement_selection_run_former_assert.svh */
// Assertion macros for the replacement-selection run former checker.
`ifndef REPLACEMENT_SELECTION_RUN_FORMER_ASSERT_SVH
`define REPLACEMENT_SELECTION_RUN_FORMER_ASSERT_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define RSRF_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define RSRF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/rsrf_pkg.sv */
// Shared types and constants of the replacement-selection run former.
package rsrf_pkg;

   localparam int BUFFER_DEPTH = 8;
   localparam int MAX_RESULTS  = 8;
   localparam int IDX_W        = $clog2(BUFFER_DEPTH);
   localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);
   localparam int RES_W        = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

   typedef logic signed [31:0] key_type;
   typedef logic [15:0]        tag_type;
   typedef logic [15:0]        run_type;
   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [FILL_W-1:0]  fill_type;
   typedef logic [RES_W-1:0]   res_cnt_type;

   // Item kinds
   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_FLUSH  = 1'b1;

   // Min-search token handed from cell to cell
   typedef struct packed {
      logic    found;
      key_type key;
      tag_type tag;
      idx_type idx;
   } token_type;

   // Per-cell write controls
   typedef struct packed {
      logic load;
      logic load_frozen;
      logic clear;
      logic thaw;
   } cell_ctl_type;

   // Per-cell status flags
   typedef struct packed {
      logic valid;
      logic frozen;
   } cell_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

endpackage

/* hdl/replacement_selection_run_former.sv */
// Replacement-selection run former: top level with control and the row of slot cells.
//
// Records enter on start while busy is low. While the buffer of BUFFER_DEPTH slots
// fills, a record goes into the lowest empty slot and gives no result. Once full, a
// record takes the accept cycle, a search in which a search token walks one cell per
// cycle along the slot chain to find the smallest unfrozen key, and an update cycle;
// its single result is shown on the cycle after the update. A flush repeats search
// and update, one result each, at most MAX_RESULTS per item, and busy stays high until
// the last update. Each result is on the rsp_ ports for exactly one cycle, marked by
// rsp_valid; the receiver cannot hold results off, so it must take every strobe.
module replacement_selection_run_former (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_kind,
   input  rsrf_pkg::key_type req_record_key,
   input  rsrf_pkg::tag_type req_record_tag,
   output logic              rsp_valid,
   output rsrf_pkg::key_type rsp_out_key,
   output rsrf_pkg::tag_type rsp_out_tag,
   output rsrf_pkg::run_type rsp_run_number,
   output logic              rsp_end_of_run,
   output logic              rsp_last_result
);
   import rsrf_pkg::*;

   state_type     state_ff, state_in;
   idx_type       scan_cnt_ff, scan_cnt_in;
   res_cnt_type   res_cnt_ff, res_cnt_in;
   fill_type      fill_ff, fill_in;
   run_type       run_ff, run_in;
   logic          mode_ff, mode_in;
   key_type       new_key_ff, new_key_in;
   tag_type       new_tag_ff, new_tag_in;

   logic          rsp_valid_ff, rsp_valid_in;
   key_type       rsp_key_ff, rsp_key_in;
   tag_type       rsp_tag_ff, rsp_tag_in;
   run_type       rsp_run_ff, rsp_run_in;
   logic          rsp_eor_ff, rsp_eor_in;
   logic          rsp_last_ff, rsp_last_in;

   cell_ctl_type  ctl [BUFFER_DEPTH];
   cell_stat_type stat [BUFFER_DEPTH];
   token_type     tok_chain [BUFFER_DEPTH+1];
   token_type     winner;
   key_type       wr_key;
   tag_type       wr_tag;

   logic [BUFFER_DEPTH-1:0] unfrozen;
   logic [BUFFER_DEPTH-1:0] win_onehot;
   logic [BUFFER_DEPTH-1:0] unfrozen_after;
   logic          any_unfrozen;
   logic          fill_full;
   logic          accept;
   logic          new_frozen;
   logic          eor;
   logic          flush_last;
   idx_type       free_idx;

   // Cell row
   assign tok_chain[0] = '0;

   for (genvar g = 0; g < BUFFER_DEPTH; g++) begin : g_cell
      rsrf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (idx_type'(g)),
         .ctl      (ctl[g]),
         .wr_key   (wr_key),
         .wr_tag   (wr_tag),
         .tok_prev (tok_chain[g]),
         .tok_next (tok_chain[g+1]),
         .stat     (stat[g])
      );
   end

   assign winner = tok_chain[BUFFER_DEPTH];
   assign wr_key = (state_ff == ST_IDLE) ? req_record_key : new_key_ff;
   assign wr_tag = (state_ff == ST_IDLE) ? req_record_tag : new_tag_ff;

   // Slot flags and lowest empty slot
   always_comb begin
      free_idx = '0;
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
         unfrozen[i]   = stat[i].valid && !stat[i].frozen;
         win_onehot[i] = (winner.idx == idx_type'(i));
      end
      for (int i = BUFFER_DEPTH - 1; i >= 0; i--) begin
         if (!stat[i].valid) begin
            free_idx = idx_type'(i);
         end
      end
   end

   assign any_unfrozen = |unfrozen;
   assign fill_full    = (fill_ff == fill_type'(BUFFER_DEPTH));
   assign accept       = start && !busy;
   assign new_frozen   = new_key_ff < winner.key;
   assign flush_last   = (fill_ff == fill_type'(1)) ||
                         (res_cnt_ff == res_cnt_type'(MAX_RESULTS - 1));

   // Run ends when no unfrozen slot is left after this update
   always_comb begin
      if (mode_ff == KIND_FLUSH) begin
         unfrozen_after = unfrozen & ~win_onehot;
      end else begin
         unfrozen_after = unfrozen & ~(new_frozen ? win_onehot : '0);
      end
      eor = (unfrozen_after == '0);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && ((req_kind == KIND_FLUSH) ? (fill_ff != '0) : fill_full)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff == idx_type'(BUFFER_DEPTH - 1)) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (mode_ff == KIND_FLUSH && winner.found && !flush_last) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and cell controls
   always_comb begin
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
         ctl[i] = '0;
      end
      scan_cnt_in  = '0;
      res_cnt_in   = res_cnt_ff;
      fill_in      = fill_ff;
      run_in       = run_ff;
      mode_in      = mode_ff;
      new_key_in   = new_key_ff;
      new_tag_in   = new_tag_ff;
      rsp_valid_in = 1'b0;
      rsp_key_in   = rsp_key_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_eor_in   = rsp_eor_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in    = req_kind;
               new_key_in = req_record_key;
               new_tag_in = req_record_tag;
               res_cnt_in = '0;
               if (req_kind == KIND_RECORD && !fill_full) begin
                  // Filling: lowest empty slot, no result
                  ctl[free_idx].load = 1'b1;
                  fill_in = fill_ff + fill_type'(1);
               end else if (!any_unfrozen) begin
                  // All frozen before a search: start afresh
                  for (int i = 0; i < BUFFER_DEPTH; i++) begin
                     ctl[i].thaw = 1'b1;
                  end
               end
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + idx_type'(1);
         end
         ST_APPLY: begin
            if (winner.found) begin
               rsp_valid_in = 1'b1;
               rsp_key_in   = winner.key;
               rsp_tag_in   = winner.tag;
               rsp_run_in   = run_ff;
               rsp_eor_in   = eor;
               if (mode_ff == KIND_FLUSH) begin
                  ctl[winner.idx].clear = 1'b1;
                  fill_in     = fill_ff - fill_type'(1);
                  res_cnt_in  = res_cnt_ff + res_cnt_type'(1);
                  rsp_last_in = flush_last;
               end else begin
                  ctl[winner.idx].load        = 1'b1;
                  ctl[winner.idx].load_frozen = new_frozen;
                  rsp_last_in = 1'b1;
               end
               if (eor) begin
                  for (int i = 0; i < BUFFER_DEPTH; i++) begin
                     ctl[i].thaw = 1'b1;
                  end
                  run_in = run_ff + run_type'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         res_cnt_ff   <= '0;
         fill_ff      <= '0;
         run_ff       <= '0;
         mode_ff      <= KIND_RECORD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         res_cnt_ff   <= res_cnt_in;
         fill_ff      <= fill_in;
         run_ff       <= run_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      new_key_ff  <= new_key_in;
      new_tag_ff  <= new_tag_in;
      rsp_key_ff  <= rsp_key_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_run_ff  <= rsp_run_in;
      rsp_eor_ff  <= rsp_eor_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_tag     = rsp_tag_ff;
   assign rsp_run_number  = rsp_run_ff;
   assign rsp_end_of_run  = rsp_eor_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

/* hdl/rsrf_cell.sv */
// One buffer slot of the run former, with its stage of the min-search chain.
module rsrf_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  rsrf_pkg::idx_type      cell_idx,
   input  rsrf_pkg::cell_ctl_type ctl,
   input  rsrf_pkg::key_type      wr_key,
   input  rsrf_pkg::tag_type      wr_tag,
   input  rsrf_pkg::token_type    tok_prev,
   output rsrf_pkg::token_type    tok_next,
   output rsrf_pkg::cell_stat_type stat
);
   import rsrf_pkg::*;

   key_type   key_ff, key_in;
   tag_type   tag_ff, tag_in;
   logic      valid_ff, valid_in;
   logic      frozen_ff, frozen_in;
   token_type tok_ff, tok_in;
   logic      take;

   // Slot update: load, then clear, then thaw override
   always_comb begin
      key_in    = key_ff;
      tag_in    = tag_ff;
      valid_in  = valid_ff;
      frozen_in = frozen_ff;
      if (ctl.load) begin
         key_in    = wr_key;
         tag_in    = wr_tag;
         valid_in  = 1'b1;
         frozen_in = ctl.load_frozen;
      end
      if (ctl.clear) begin
         valid_in  = 1'b0;
         frozen_in = 1'b0;
      end
      if (ctl.thaw) begin
         frozen_in = 1'b0;
      end
   end

   // Search stage: strict less-than keeps the lower slot on equal keys
   always_comb begin
      take = valid_ff && !frozen_ff && (!tok_prev.found || (key_ff < tok_prev.key));
      if (take) begin
         tok_in.found = 1'b1;
         tok_in.key   = key_ff;
         tok_in.tag   = tag_ff;
         tok_in.idx   = cell_idx;
      end else begin
         tok_in = tok_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         frozen_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         frozen_ff <= frozen_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
      tok_ff <= tok_in;
   end

   assign tok_next    = tok_ff;
   assign stat.valid  = valid_ff;
   assign stat.frozen = frozen_ff;

endmodule

/* hdl/rsrf_checker.sv */
// Port-level checker for the run former, bound to the top level.
`include "replacement_selection_run_former_assert.svh"

module rsrf_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_last_result
);

   // Results of one flush are spaced by a full search
   `RSRF_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid, "back-to-back result strobes")

   // More results pending: no new item may be taken
   `RSRF_ASSERT_SAME(a_burst_busy, rsp_valid && !rsp_last_result, busy, "idle before last result")

   // Final result of an item frees the block
   `RSRF_ASSERT_SAME(a_last_frees, rsp_valid && rsp_last_result, !busy, "busy after last result")

endmodule

bind replacement_selection_run_former rsrf_checker u_rsrf_checker (.*);

/* tb/tb.sv */
// Testbench for the replacement-selection run former: directed and random records and flushes.
`timescale 1ns / 1ps

import rsrf_pkg::*;

// One emitted record as seen on the rsp_ ports
typedef struct {
   key_type key;
   tag_type tag;
   run_type run;
   logic    eor;
   logic    last;
} emitted_rec_type;

// Run former model and expected-emit store
class run_order_checker;
   key_type         slot_key[BUFFER_DEPTH];
   tag_type         slot_tag[BUFFER_DEPTH];
   bit              slot_used[BUFFER_DEPTH];
   bit              slot_cold[BUFFER_DEPTH];
   int              fill;
   run_type         run_idx;
   emitted_rec_type expected_emits[$];
   int              errors;

   function new();
      fill    = 0;
      run_idx = '0;
      errors  = 0;
      foreach (slot_used[i]) begin
         slot_used[i] = 1'b0;
         slot_cold[i] = 1'b0;
         slot_key[i]  = '0;
         slot_tag[i]  = '0;
      end
   endfunction

   function int pending();
      return expected_emits.size();
   endfunction

   // Smallest key among used slots of the given frozen state; lowest index wins ties
   function int min_slot(bit want_cold);
      int pick;
      pick = -1;
      for (int i = 0; i < BUFFER_DEPTH; i++) begin
         if (slot_used[i] && slot_cold[i] == want_cold &&
             (pick < 0 || slot_key[i] < slot_key[pick]))
            pick = i;
      end
      return pick;
   endfunction

   function void thaw_all();
      foreach (slot_cold[i]) slot_cold[i] = 1'b0;
   endfunction

   // Closes the run when no unfrozen record is left
   function bit close_run();
      if (min_slot(1'b0) >= 0) return 1'b0;
      thaw_all();
      return 1'b1;
   endfunction

   function void push_emit(key_type key, tag_type tag, bit eor, bit last);
      emitted_rec_type r;
      r.key  = key;
      r.tag  = tag;
      r.run  = run_idx;
      r.eor  = eor;
      r.last = last;
      expected_emits.push_back(r);
      if (eor) run_idx = run_idx + 1'b1;
   endfunction

   // Works out the records emitted by one accepted item
   function void predict_item(logic kind, key_type key, tag_type tag);
      int      idx;
      int      n;
      key_type old_key;
      tag_type old_tag;
      bit      eor;
      bit      last;
      if (kind == KIND_RECORD) begin
         // still filling: lowest empty slot, nothing emitted
         if (fill < BUFFER_DEPTH) begin
            for (int i = 0; i < BUFFER_DEPTH; i++) begin
               if (!slot_used[i]) begin
                  slot_key[i]  = key;
                  slot_tag[i]  = tag;
                  slot_used[i] = 1'b1;
                  slot_cold[i] = 1'b0;
                  fill++;
                  break;
               end
            end
            return;
         end
         idx = min_slot(1'b0);
         if (idx < 0) begin
            thaw_all();
            idx = min_slot(1'b0);
            if (idx < 0) return;
         end
         old_key = slot_key[idx];
         old_tag = slot_tag[idx];
         slot_key[idx]  = key;
         slot_tag[idx]  = tag;
         slot_cold[idx] = key < old_key;
         eor = close_run();
         push_emit(old_key, old_tag, eor, 1'b1);
      end else begin
         // flush: drain unfrozen in order, then the frozen ones as a new run
         n = 0;
         if (fill > 0 && min_slot(1'b0) < 0) thaw_all();
         while (n < MAX_RESULTS) begin
            idx = min_slot(1'b0);
            if (idx < 0) break;
            slot_used[idx] = 1'b0;
            slot_cold[idx] = 1'b0;
            if (fill > 0) fill--;
            eor  = close_run();
            last = (fill == 0) || (n + 1 == MAX_RESULTS);
            push_emit(slot_key[idx], slot_tag[idx], eor, last);
            n++;
         end
      end
   endfunction

   task report(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      errors++;
   endtask

   // Compares one emitted record with the oldest expectation
   task check_emit(key_type key, tag_type tag, run_type run, logic eor, logic last);
      emitted_rec_type w;
      if (expected_emits.size() == 0) begin
         report("unexpected record, key", key, '0);
         return;
      end
      w = expected_emits.pop_front();
      if (key !== w.key)   report("out_key", key, w.key);
      if (tag !== w.tag)   report("out_tag", 32'(tag), 32'(w.tag));
      if (run !== w.run)   report("run_number", 32'(run), 32'(w.run));
      if (eor !== w.eor)   report("end_of_run", 32'(eor), 32'(w.eor));
      if (last !== w.last) report("last_result", 32'(last), 32'(w.last));
   endtask
endclass

module tb;
   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   logic    req_kind;
   key_type req_record_key;
   tag_type req_record_tag;
   logic    rsp_valid;
   key_type rsp_out_key;
   tag_type rsp_out_tag;
   run_type rsp_run_number;
   logic    rsp_end_of_run;
   logic    rsp_last_result;

   run_order_checker sb;

   localparam int RANDOM_ITEMS = 200;
   localparam int QUIET_TAIL   = 40;
   localparam int DRAIN_CYCLES = 2 * MAX_RESULTS * (BUFFER_DEPTH + 2);

   replacement_selection_run_former dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_record_key  (req_record_key),
      .req_record_tag  (req_record_tag),
      .rsp_valid       (rsp_valid),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_tag     (rsp_out_tag),
      .rsp_run_number  (rsp_run_number),
      .rsp_end_of_run  (rsp_end_of_run),
      .rsp_last_result (rsp_last_result)
   );

   // 2 ns clock
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Watch both channels: check emitted records, note accepted items
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_emit(rsp_out_key, rsp_out_tag, rsp_run_number,
                          rsp_end_of_run, rsp_last_result);
         if (start && !busy)
            sb.predict_item(req_kind, req_record_key, req_record_tag);
      end
   end

   // Present one item and hold it until the block takes it
   task automatic send_item(logic kind, key_type key, tag_type tag);
      start          <= 1'b1;
      req_kind       <= kind;
      req_record_key <= key;
      req_record_tag <= tag;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_record(key_type key, tag_type tag);
      send_item(KIND_RECORD, key, tag);
   endtask

   task automatic send_flush();
      send_item(KIND_FLUSH, key_type'($urandom), tag_type'($urandom));
   endtask

   task automatic pause_sender(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold off until every expected record has been seen
   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Hard limit on run time
   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      key_type fill_keys[BUFFER_DEPTH];
      key_type key;
      key_type walk_key;
      int      style;
      int      gap;
      bit      quiet;

      sb             = new();
      reset          = 1'b1;
      start          = 1'b0;
      req_kind       = KIND_RECORD;
      req_record_key = '0;
      req_record_tag = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: flush on empty buffer gives nothing
      send_flush();

      // Fill with a tie between two slots, tags at both extremes
      fill_keys = '{12, 10, 12, 15, 11, 17, 14, 16};
      for (int i = 0; i < BUFFER_DEPTH; i++)
         send_record(fill_keys[i], (i == 0) ? 16'h0000 : (i == 1) ? 16'hFFFF : tag_type'(i));

      // Descending keys freeze every slot in turn and close the run
      for (int i = 0; i < BUFFER_DEPTH; i++)
         send_record(9 - i, tag_type'(16'h100 + i));

      // Extreme keys, then a key equal to the emitted one
      send_record(32'sh8000_0000, 16'hFFFF);
      send_record(32'sh7FFF_FFFF, 16'h0000);
      send_record(4, 16'h0004);

      // Flush of a mixed frozen / unfrozen buffer
      send_flush();
      wait_drained();

      // Random part: bursts of one key style, occasional flushes
      walk_key = 0;
      style    = 0;
      quiet    = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 20 == 0) begin
            style    = $urandom_range(0, 3);
            quiet    = ($urandom_range(0, 2) == 0);
            walk_key = key_type'($urandom);
         end
         if (n == RANDOM_ITEMS / 2) wait_drained();

         if ($urandom_range(0, 15) == 0) begin
            send_flush();
         end else begin
            case (style)
               0: key = key_type'($urandom);
               1: key = key_type'($urandom_range(0, 40)) - 20;
               2: begin
                  walk_key = walk_key - key_type'($urandom_range(1, 1000));
                  key      = walk_key;
               end
               default: begin
                  case ($urandom_range(0, 3))
                     0: key = 32'sh7FFF_FFFF;
                     1: key = 32'sh8000_0000;
                     default: begin
                        walk_key = walk_key + key_type'($urandom_range(0, 1000));
                        key      = walk_key;
                     end
                  endcase
               end
            endcase
            send_record(key, tag_type'($urandom));
         end

         // Sender idles in short bursts, never in the closing stretch
         if (!quiet && n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 6);
            pause_sender(gap);
         end
      end
      send_flush();

      wait_drained();
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
